// File: hdl/mpi_pkg.sv
package mpi_pkg;

    localparam int MOD_W  = 31;
    localparam int BASE_W = 64;
    localparam int EXP_W  = 63;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_FIX,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

endpackage

// File: hdl/mpi_mulmod.sv
module mpi_mulmod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mpi_pkg::MOD_W-1:0] i_a,
    input  logic [mpi_pkg::MOD_W-1:0] i_b,
    input  logic [mpi_pkg::MOD_W-1:0] i_m,
    output logic                      o_done,
    output logic [mpi_pkg::MOD_W-1:0] o_product
);
    import mpi_pkg::*;

    localparam int CNT_W = $clog2(MOD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0] r_a;
    logic [MOD_W-1:0] r_b;
    logic [MOD_W-1:0] r_acc;

    logic [MOD_W+1:0] n_t0;
    logic [MOD_W+1:0] n_t1;
    logic [MOD_W+1:0] n_t2;
    logic [MOD_W+1:0] w_m;

    // One multiplier bit per cycle, most significant first. The accumulator
    // stays below m, so 2*acc + a is below 3m and two subtractions suffice.
    always_comb begin
        w_m  = {2'b00, i_m};
        n_t0 = {1'b0, r_acc, 1'b0} + (r_b[MOD_W-1] ? {2'b00, r_a} : '0);
        n_t1 = (n_t0 >= w_m) ? (n_t0 - w_m) : n_t0;
        n_t2 = (n_t1 >= w_m) ? (n_t1 - w_m) : n_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_t2[MOD_W-1:0];
            r_b   <= {r_b[MOD_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: hdl/mpi_reduce.sv
module mpi_reduce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mpi_pkg::BASE_W-1:0] i_mag,
    input  logic [mpi_pkg::MOD_W-1:0]  i_m,
    output logic                       o_done,
    output logic [mpi_pkg::MOD_W-1:0]  o_rem
);
    import mpi_pkg::*;

    localparam int CNT_W = $clog2(BASE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BASE_W-1:0] r_mag;
    logic [MOD_W-1:0]  r_rem;

    logic [MOD_W:0] n_t;
    logic [MOD_W:0] n_r;

    // Restoring remainder: shift in one dividend bit, subtract m when it fits.
    always_comb begin
        n_t = {r_rem, r_mag[BASE_W-1]};
        n_r = (n_t >= {1'b0, i_m}) ? (n_t - {1'b0, i_m}) : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[BASE_W-2:0], 1'b0};
            r_rem <= n_r[MOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hdl/modular_power_and_inverse_top.sv
// Modular power and Fermat inverse by square and multiply.
//
// Input stream: tuser carries the action (0 = power, 1 = inverse), tdata
// carries the signed base and the exponent. Each request gives one result on
// the output stream. The modulus is written through the config channel,
// which is always ready; write it only while no request is in flight.
//
// Operation: the base is first reduced (one dividend bit per cycle); then
// for every set exponent bit there is a multiply and, for every bit below
// the highest set one, a squaring, all on one bit-serial multiply unit (one
// multiplier bit per cycle). Inverse mode scans the 31 bits of modulus-2. A
// new request is taken only once the previous one has reached the output
// register. With a modulus of zero the result is 0, without reduction or
// multiply.
//
// Reset restores the modulus to 1000000007 and drops any request in flight.
// When the receiver stalls, a finished result waits in the output register
// and the next request can still be taken; its own result then waits until
// the register is free.
module modular_power_and_inverse_top #(
    parameter int EXPONENT_BITS = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // base [63:0], exponent [126:64], zero [127]
    input  logic         i_s_tuser,   // action [0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,   // result [30:0], zero [31]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data   // modulus [30:0]
);
    import mpi_pkg::*;

    localparam int EW = (EXPONENT_BITS > MOD_W) ? EXPONENT_BITS : MOD_W;

    t_state r_state;
    t_state n_state;

    logic [MOD_W-1:0] r_modulus;
    logic [MOD_W-1:0] r_base;
    logic [MOD_W-1:0] r_res;
    logic [EW-1:0]    r_exp;
    logic             r_neg;
    logic             r_out_valid;
    logic [MOD_W-1:0] r_out_data;

    logic              w_accept;
    logic [BASE_W-1:0] w_base_in;
    logic [BASE_W-1:0] w_mag;
    logic [EW-1:0]     w_exp_in;
    logic [MOD_W-1:0]  w_inv_exp;
    logic              w_load_out;

    logic             red_start;
    logic             red_done;
    logic [MOD_W-1:0] red_rem;
    logic             mul_start;
    logic             mul_done;
    logic [MOD_W-1:0] mul_a;
    logic [MOD_W-1:0] mul_product;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_out_data};

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_base_in = i_s_tdata[BASE_W-1:0];
    assign w_mag     = w_base_in[BASE_W-1] ? (~w_base_in + 64'd1) : w_base_in;
    assign w_inv_exp = (r_modulus >= 31'd2) ? (r_modulus - 31'd2) : '0;
    assign w_exp_in  = i_s_tuser ? EW'(w_inv_exp)
                                 : EW'(i_s_tdata[BASE_W +: EXPONENT_BITS]);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    mpi_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_mag   (w_mag),
        .i_m     (r_modulus),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    mpi_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (r_base),
        .i_m       (r_modulus),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The step state consumes the exponent from its low end: a set bit costs
    // a multiply into the result, and the base is squared only while higher
    // bits remain.
    always_comb begin
        n_state   = r_state;
        red_start = 1'b0;
        mul_start = 1'b0;
        mul_a     = r_base;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_modulus == '0) begin
                        n_state = S_DONE;
                    end else begin
                        red_start = 1'b1;
                        n_state   = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (red_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_a     = r_res;
                    n_state   = S_MUL;
                end else begin
                    mul_start = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_STEP;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_neg <= w_base_in[BASE_W-1];
                    r_exp <= w_exp_in;
                    r_res <= '0;
                end
            end
            S_FIX: begin
                // Lift a negative remainder into 0..m-1.
                r_base <= (r_neg && red_rem != '0) ? (r_modulus - red_rem) : red_rem;
                r_res  <= (r_modulus == 31'd1) ? '0 : 31'd1;
            end
            S_MUL: begin
                if (mul_done) begin
                    r_res    <= mul_product;
                    r_exp[0] <= 1'b0;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    r_base <= mul_product;
                    r_exp  <= r_exp >> 1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_res;
        end
    end

    a_red_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_done |-> (r_state == S_REDUCE))
        else $error("reduce unit finished outside the reduce state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL || r_state == S_SQR))
        else $error("multiply unit finished outside a multiply state");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_REDUCE || r_state == S_DONE))
        else $error("accepted request did not start");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_out_valid) |-> i_m_tready)
        else $error("output register overwritten while occupied");

endmodule
